// ===== hdl/drb_pkg.sv =====
// shared types, widths and register codes of the depth ray back-projection block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package drb_pkg;

  // field widths
  localparam int COL_W      = 12;
  localparam int ROW_W      = 12;
  localparam int DEPTH_W    = 20;
  localparam int FOCAL_W    = 21;
  localparam int CENTER_W   = 20;
  localparam int COLOR_W    = 8;
  localparam int POINT_XY_W = 21;

  // datapath widths
  localparam int DIFF_W  = 22;               // u*256 - cx
  localparam int PROD_W  = DIFF_W + FOCAL_W; // signed products
  localparam int MAG_W   = PROD_W - 1;       // their magnitudes
  localparam int NORM_W  = 31;               // magnitudes after scaling
  localparam int SHIFT_W = $clog2(MAG_W - NORM_W + 1);
  localparam int SQ_W    = 2 * NORM_W;
  localparam int SUM_W   = 64;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int NUM_W   = ROOT_W + DEPTH_W;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 21;

  localparam int COLUMN_LIMIT_DEFAULT = 4096;
  localparam int ROW_LIMIT_DEFAULT    = 4096;
  localparam int FIFO_DEPTH_DEFAULT   = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FOCAL_X  = 3'd0,
    REG_FOCAL_Y  = 3'd1,
    REG_CENTER_X = 3'd2,
    REG_CENTER_Y = 3'd3,
    REG_MIN_DEPTH = 3'd4,
    REG_MAX_DEPTH = 3'd5
  } reg_index_t;

  localparam logic signed [FOCAL_W-1:0] FOCAL_X_RESET = 21'sd123187;
  localparam logic signed [FOCAL_W-1:0] FOCAL_Y_RESET = -21'sd122880;
  localparam logic [CENTER_W-1:0] CENTER_X_RESET  = 20'd81792;
  localparam logic [CENTER_W-1:0] CENTER_Y_RESET  = 20'd61312;
  localparam logic [DEPTH_W-1:0]  MIN_DEPTH_RESET = 20'd655;
  localparam logic [DEPTH_W-1:0]  MAX_DEPTH_RESET = 20'd655360;

  localparam logic [COLOR_W-1:0] WHITE = 8'd255;

  typedef struct packed {
    logic signed [FOCAL_W-1:0] focal_x;
    logic signed [FOCAL_W-1:0] focal_y;
    logic [CENTER_W-1:0]       center_x;
    logic [CENTER_W-1:0]       center_y;
    logic [DEPTH_W-1:0]        min_depth;
    logic [DEPTH_W-1:0]        max_depth;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

  // one classified ray handed from front to back
  typedef struct packed {
    logic [NORM_W-1:0]  mag_x;
    logic [NORM_W-1:0]  mag_y;
    logic [NORM_W-1:0]  mag_z;
    logic [DEPTH_W-1:0] depth;
    logic               neg_x;
    logic               neg_y;
    color_t             color;
  } ray_t;

endpackage

`default_nettype wire

// ===== hdl/drb_channels.sv =====
// valid/ready channel interfaces for depth pixels in and points out
// depends on drb_pkg
`timescale 1ns / 1ps
`default_nettype none

interface drb_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [drb_pkg::COL_W-1:0]     pixel_col;
  logic [drb_pkg::ROW_W-1:0]     pixel_row;
  logic [drb_pkg::DEPTH_W-1:0]   ray_depth;
  logic                          color_present;
  logic [drb_pkg::COLOR_W-1:0]   in_red;
  logic [drb_pkg::COLOR_W-1:0]   in_green;
  logic [drb_pkg::COLOR_W-1:0]   in_blue;

  modport source (output valid, pixel_col, pixel_row, ray_depth, color_present,
                  in_red, in_green, in_blue, input ready);
  modport sink (input valid, pixel_col, pixel_row, ray_depth, color_present,
                in_red, in_green, in_blue, output ready);
endinterface

interface drb_point_if;
  logic                                valid;
  logic                                ready;
  logic signed [drb_pkg::POINT_XY_W-1:0] point_x;
  logic signed [drb_pkg::POINT_XY_W-1:0] point_y;
  logic [drb_pkg::DEPTH_W-1:0]         point_z;
  logic [drb_pkg::COLOR_W-1:0]         out_red;
  logic [drb_pkg::COLOR_W-1:0]         out_green;
  logic [drb_pkg::COLOR_W-1:0]         out_blue;

  modport source (output valid, point_x, point_y, point_z, out_red, out_green,
                  out_blue, input ready);
  modport sink (input valid, point_x, point_y, point_z, out_red, out_green,
                out_blue, output ready);
endinterface

`default_nettype wire

// ===== hdl/drb_front.sv =====
// front end: accepts depth pixels, drops out-of-range ones, forms scaled ray terms
// depends on drb_pkg and drb_channels
`timescale 1ns / 1ps
`default_nettype none

module drb_front #(
  parameter int COLUMN_LIMIT = drb_pkg::COLUMN_LIMIT_DEFAULT,
  parameter int ROW_LIMIT    = drb_pkg::ROW_LIMIT_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  drb_pixel_if.sink     pixel,
  input  drb_pkg::cfg_t cfg,
  input  logic          full,
  output logic          push,
  output drb_pkg::ray_t push_data
);

  logic en;
  logic pass;

  // stage 0
  logic                                v0;
  logic signed [drb_pkg::DIFF_W-1:0]   a0;
  logic signed [drb_pkg::DIFF_W-1:0]   b0;
  logic [drb_pkg::DEPTH_W-1:0]         depth0;
  drb_pkg::color_t                     color0;
  // stage 1
  logic                                v1;
  logic signed [drb_pkg::PROD_W-1:0]   prod_x1;
  logic signed [drb_pkg::PROD_W-1:0]   prod_y1;
  logic signed [drb_pkg::PROD_W-1:0]   prod_z1;
  logic                                neg_x1;
  logic                                neg_y1;
  logic [drb_pkg::DEPTH_W-1:0]         depth1;
  drb_pkg::color_t                     color1;
  // stage 2
  logic                                v2;
  logic [drb_pkg::MAG_W-1:0]           mag_x2;
  logic [drb_pkg::MAG_W-1:0]           mag_y2;
  logic [drb_pkg::MAG_W-1:0]           mag_z2;
  logic                                neg_x2;
  logic                                neg_y2;
  logic [drb_pkg::DEPTH_W-1:0]         depth2;
  drb_pkg::color_t                     color2;
  // stage 3
  logic                                v3;
  logic [drb_pkg::MAG_W-1:0]           or_bits;
  logic [drb_pkg::SHIFT_W-1:0]         shift;
  logic [drb_pkg::MAG_W-1:0]           sh_x;
  logic [drb_pkg::MAG_W-1:0]           sh_y;
  logic [drb_pkg::MAG_W-1:0]           sh_z;

  assign en          = !full;
  assign pixel.ready = en;
  assign push        = v3 && en;

  assign pass = (pixel.ray_depth > cfg.min_depth) && (pixel.ray_depth < cfg.max_depth)
             && (cfg.focal_x != '0) && (cfg.focal_y != '0)
             && (32'(pixel.pixel_col) < 32'(COLUMN_LIMIT))
             && (32'(pixel.pixel_row) < 32'(ROW_LIMIT));

  // smallest right shift that brings the largest magnitude below 2^31
  always_comb begin
    or_bits = mag_x2 | mag_y2 | mag_z2;
    shift   = '0;
    for (int i = drb_pkg::NORM_W; i < drb_pkg::MAG_W; i++) begin
      if (or_bits[i]) shift = drb_pkg::SHIFT_W'(i - drb_pkg::NORM_W + 1);
    end
    sh_x = mag_x2 >> shift;
    sh_y = mag_y2 >> shift;
    sh_z = mag_z2 >> shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= pixel.valid && pass;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
    if (en) begin
      a0 <= $signed({2'b00, pixel.pixel_col, 8'b0}) - $signed({2'b00, cfg.center_x});
      b0 <= $signed({2'b00, pixel.pixel_row, 8'b0}) - $signed({2'b00, cfg.center_y});
      depth0 <= pixel.ray_depth;
      if (pixel.color_present) begin
        color0 <= '{red: pixel.in_red, green: pixel.in_green, blue: pixel.in_blue};
      end else begin
        color0 <= '{red: drb_pkg::WHITE, green: drb_pkg::WHITE, blue: drb_pkg::WHITE};
      end

      prod_x1 <= a0 * $signed(cfg.focal_y);
      prod_y1 <= b0 * $signed(cfg.focal_x);
      prod_z1 <= $signed(cfg.focal_x) * $signed(cfg.focal_y);
      neg_x1  <= a0[drb_pkg::DIFF_W-1] ^ cfg.focal_x[drb_pkg::FOCAL_W-1];
      neg_y1  <= b0[drb_pkg::DIFF_W-1] ^ cfg.focal_y[drb_pkg::FOCAL_W-1];
      depth1  <= depth0;
      color1  <= color0;

      mag_x2 <= prod_x1[drb_pkg::PROD_W-1] ? drb_pkg::MAG_W'(-prod_x1)
                                           : drb_pkg::MAG_W'(prod_x1);
      mag_y2 <= prod_y1[drb_pkg::PROD_W-1] ? drb_pkg::MAG_W'(-prod_y1)
                                           : drb_pkg::MAG_W'(prod_y1);
      mag_z2 <= prod_z1[drb_pkg::PROD_W-1] ? drb_pkg::MAG_W'(-prod_z1)
                                           : drb_pkg::MAG_W'(prod_z1);
      neg_x2 <= neg_x1;
      neg_y2 <= neg_y1;
      depth2 <= depth1;
      color2 <= color1;

      push_data.mag_x <= sh_x[drb_pkg::NORM_W-1:0];
      push_data.mag_y <= sh_y[drb_pkg::NORM_W-1:0];
      push_data.mag_z <= sh_z[drb_pkg::NORM_W-1:0];
      push_data.depth <= depth2;
      push_data.neg_x <= neg_x2;
      push_data.neg_y <= neg_y2;
      push_data.color <= color2;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/drb_fifo.sv =====
// short ray queue between front and back
// depends on drb_pkg
`timescale 1ns / 1ps
`default_nettype none

module drb_fifo #(
  parameter int DEPTH = drb_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  drb_pkg::ray_t push_data,
  input  logic          pop,
  output drb_pkg::ray_t pop_data,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  drb_pkg::ray_t     mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ===== hdl/drb_sqrt.sv =====
// pipelined integer square root, one result bit per stage, with side payload
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module drb_sqrt #(
  parameter int IN_W  = 64,
  parameter int PAY_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     radicand,
  input  logic [PAY_W-1:0]    in_pay,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   root_out,
  output logic [PAY_W-1:0]    out_pay
);

  localparam int RW    = IN_W / 2;
  localparam int REM_W = RW + 2;

  logic [REM_W-1:0] rem  [RW];
  logic [RW-1:0]    root [RW];
  logic [IN_W-1:0]  rad  [RW];
  logic [PAY_W-1:0] pay  [RW];
  logic             vld  [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [RW-1:0]    root_in;
    logic [IN_W-1:0]  rad_in;
    logic [PAY_W-1:0] pay_in;
    logic             v_in;

    if (j == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand;
      assign pay_in  = in_pay;
      assign v_in    = in_valid;
    end else begin : g_next
      assign rem_in  = rem[j-1];
      assign root_in = root[j-1];
      assign rad_in  = rad[j-1];
      assign pay_in  = pay[j-1];
      assign v_in    = vld[j-1];
    end

    assign rem_sh = {rem_in[RW-1:0], rad_in[IN_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) vld[j] <= 1'b0;
      else if (en) vld[j] <= v_in;
      if (en) begin
        if (rem_sh >= trial) begin
          rem[j]  <= rem_sh - trial;
          root[j] <= {root_in[RW-2:0], 1'b1};
        end else begin
          rem[j]  <= rem_sh;
          root[j] <= {root_in[RW-2:0], 1'b0};
        end
        rad[j] <= rad_in << 2;
        pay[j] <= pay_in;
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign root_out  = root[RW-1];
  assign out_pay   = pay[RW-1];

endmodule

`default_nettype wire

// ===== hdl/drb_div.sv =====
// pipelined restoring divider, lanes share one divisor, one quotient bit per stage
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module drb_div #(
  parameter int DEN_W = 32,
  parameter int Q_W   = 20,
  parameter int LANES = 3,
  parameter int PAY_W = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [DEN_W+Q_W-1:0]   num [LANES],
  input  logic [DEN_W-1:0]       den,
  input  logic [PAY_W-1:0]       in_pay,
  output logic                   out_valid,
  output logic [Q_W-1:0]         quo_out [LANES],
  output logic [PAY_W-1:0]       out_pay
);

  localparam int NW = DEN_W + Q_W;

  logic [DEN_W-1:0] rem   [Q_W][LANES];
  logic [Q_W-1:0]   lo    [Q_W][LANES];
  logic [Q_W-1:0]   quo   [Q_W][LANES];
  logic [DEN_W-1:0] den_s [Q_W];
  logic [PAY_W-1:0] pay   [Q_W];
  logic             vld   [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [DEN_W-1:0] den_in;
    logic [PAY_W-1:0] pay_in;
    logic             v_in;

    if (j == 0) begin : g_first
      assign den_in = den;
      assign pay_in = in_pay;
      assign v_in   = in_valid;
    end else begin : g_next
      assign den_in = den_s[j-1];
      assign pay_in = pay[j-1];
      assign v_in   = vld[j-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DEN_W-1:0] rem_in;
      logic [Q_W-1:0]   lo_in;
      logic [Q_W-1:0]   quo_in;
      logic [DEN_W:0]   rem_sh;
      logic [DEN_W:0]   diff;

      if (j == 0) begin : g_first
        assign rem_in = num[l][NW-1 -: DEN_W];
        assign lo_in  = num[l][Q_W-1:0];
        assign quo_in = '0;
      end else begin : g_next
        assign rem_in = rem[j-1][l];
        assign lo_in  = lo[j-1][l];
        assign quo_in = quo[j-1][l];
      end

      assign rem_sh = {rem_in, lo_in[Q_W-1]};
      assign diff   = rem_sh - {1'b0, den_in};

      always_ff @(posedge clk) begin
        if (en) begin
          if (rem_sh >= {1'b0, den_in}) begin
            rem[j][l] <= diff[DEN_W-1:0];
            quo[j][l] <= {quo_in[Q_W-2:0], 1'b1};
          end else begin
            rem[j][l] <= rem_sh[DEN_W-1:0];
            quo[j][l] <= {quo_in[Q_W-2:0], 1'b0};
          end
          lo[j][l] <= lo_in << 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) vld[j] <= 1'b0;
      else if (en) vld[j] <= v_in;
      if (en) begin
        den_s[j] <= den_in;
        pay[j]   <= pay_in;
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo_out[l] = quo[Q_W-1][l];
  end
  assign out_valid = vld[Q_W-1];
  assign out_pay   = pay[Q_W-1];

endmodule

`default_nettype wire

// ===== hdl/drb_back.sv =====
// back end: ray length by square root, scaling by division, signed point output
// depends on drb_pkg, drb_channels, drb_sqrt and drb_div
`timescale 1ns / 1ps
`default_nettype none

module drb_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  drb_pkg::ray_t pop_data,
  output logic          pop,
  drb_point_if.source   point
);

  localparam int PAY_W = $bits(drb_pkg::ray_t);

  logic en;

  logic                        v0;
  drb_pkg::ray_t               ray0;
  logic                        v1;
  drb_pkg::ray_t               ray1;
  logic [drb_pkg::SQ_W-1:0]    sq_x1;
  logic [drb_pkg::SQ_W-1:0]    sq_y1;
  logic [drb_pkg::SQ_W-1:0]    sq_z1;
  logic                        v2;
  drb_pkg::ray_t               ray2;
  logic [drb_pkg::SUM_W-1:0]   sum2;

  logic                        sq_valid;
  logic [drb_pkg::ROOT_W-1:0]  root;
  logic [PAY_W-1:0]            sq_pay;
  drb_pkg::ray_t               ray_sq;

  logic                        v3;
  logic [PAY_W-1:0]            pay3;
  logic [drb_pkg::NUM_W-1:0]   num3 [3];
  logic [drb_pkg::ROOT_W-1:0]  den3;

  logic                        dv_valid;
  logic [drb_pkg::DEPTH_W-1:0] quo [3];
  logic [PAY_W-1:0]            dv_pay;
  drb_pkg::ray_t               ray_dv;

  // whole back end moves when the output register is free or being taken
  assign en     = !point.valid || point.ready;
  assign pop    = en && !empty;
  assign ray_sq = drb_pkg::ray_t'(sq_pay);
  assign ray_dv = drb_pkg::ray_t'(dv_pay);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= pop;
      v1 <= v0;
      v2 <= v1;
      v3 <= sq_valid;
    end
    if (en) begin
      ray0  <= pop_data;
      sq_x1 <= ray0.mag_x * ray0.mag_x;
      sq_y1 <= ray0.mag_y * ray0.mag_y;
      sq_z1 <= ray0.mag_z * ray0.mag_z;
      ray1  <= ray0;
      sum2  <= drb_pkg::SUM_W'(sq_x1) + drb_pkg::SUM_W'(sq_y1) + drb_pkg::SUM_W'(sq_z1);
      ray2  <= ray1;
      // numerator with half the divisor added, for rounding to nearest
      num3[0] <= drb_pkg::NUM_W'(ray_sq.depth * ray_sq.mag_x) + drb_pkg::NUM_W'(root >> 1);
      num3[1] <= drb_pkg::NUM_W'(ray_sq.depth * ray_sq.mag_y) + drb_pkg::NUM_W'(root >> 1);
      num3[2] <= drb_pkg::NUM_W'(ray_sq.depth * ray_sq.mag_z) + drb_pkg::NUM_W'(root >> 1);
      den3    <= root;
      pay3    <= sq_pay;
    end
  end

  drb_sqrt #(
    .IN_W  (drb_pkg::SUM_W),
    .PAY_W (PAY_W)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .radicand  (sum2),
    .in_pay    (PAY_W'(ray2)),
    .out_valid (sq_valid),
    .root_out  (root),
    .out_pay   (sq_pay)
  );

  drb_div #(
    .DEN_W (drb_pkg::ROOT_W),
    .Q_W   (drb_pkg::DEPTH_W),
    .LANES (3),
    .PAY_W (PAY_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .num       (num3),
    .den       (den3),
    .in_pay    (pay3),
    .out_valid (dv_valid),
    .quo_out   (quo),
    .out_pay   (dv_pay)
  );

  always_ff @(posedge clk) begin
    if (rst) point.valid <= 1'b0;
    else if (en) point.valid <= dv_valid;
    if (en) begin
      point.point_x <= ray_dv.neg_x ? drb_pkg::POINT_XY_W'(0) - {1'b0, quo[0]}
                                    : {1'b0, quo[0]};
      point.point_y <= ray_dv.neg_y ? drb_pkg::POINT_XY_W'(0) - {1'b0, quo[1]}
                                    : {1'b0, quo[1]};
      point.point_z   <= quo[2];
      point.out_red   <= ray_dv.color.red;
      point.out_green <= ray_dv.color.green;
      point.out_blue  <= ray_dv.color.blue;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/depth_ray_backprojection.sv =====
// top level of the depth ray back-projection block: registers, front, queue, back
// depends on drb_pkg, drb_channels, drb_front, drb_fifo and drb_back
`timescale 1ns / 1ps
`default_nettype none

// Turns depth pixels (column, row, ray length, optional colour) into 3D points
// with a pinhole camera model. A new pixel word is taken on every clock while the
// queue is not full; one point word comes out per clock when the sink keeps ready
// high. A pixel whose depth is not strictly between min_depth and max_depth, that
// lies beyond the image, or that meets a zero focal length gives no point. On its
// way a point word passes 62 registers: 4 front stages, the queue, an input, a
// squaring and a summing register, 32 square-root stages (one root bit each), a
// numerator stage, 20 divider stages (one quotient bit each) and the output
// register. Pixels without colour come out white. The camera registers are
// written through cfg_we / cfg_index / cfg_data and should only change while the
// block holds no pixels.
module depth_ray_backprojection #(
  parameter int COLUMN_LIMIT = drb_pkg::COLUMN_LIMIT_DEFAULT,
  parameter int ROW_LIMIT    = drb_pkg::ROW_LIMIT_DEFAULT,
  parameter int FIFO_DEPTH   = drb_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  drb_pixel_if.sink                        pixel,
  drb_point_if.source                      point,
  input  logic                             cfg_we,
  input  logic [drb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [drb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  drb_pkg::cfg_t cfg;      // camera and depth window registers
  logic          full;
  logic          empty;
  logic          push;
  logic          pop;
  drb_pkg::ray_t push_data;
  drb_pkg::ray_t pop_data;

  // register file, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x   <= drb_pkg::FOCAL_X_RESET;
      cfg.focal_y   <= drb_pkg::FOCAL_Y_RESET;
      cfg.center_x  <= drb_pkg::CENTER_X_RESET;
      cfg.center_y  <= drb_pkg::CENTER_Y_RESET;
      cfg.min_depth <= drb_pkg::MIN_DEPTH_RESET;
      cfg.max_depth <= drb_pkg::MAX_DEPTH_RESET;
    end else if (cfg_we) begin
      case (drb_pkg::reg_index_t'(cfg_index))
        drb_pkg::REG_FOCAL_X:   cfg.focal_x   <= cfg_data;
        drb_pkg::REG_FOCAL_Y:   cfg.focal_y   <= cfg_data;
        drb_pkg::REG_CENTER_X:  cfg.center_x  <= cfg_data[drb_pkg::CENTER_W-1:0];
        drb_pkg::REG_CENTER_Y:  cfg.center_y  <= cfg_data[drb_pkg::CENTER_W-1:0];
        drb_pkg::REG_MIN_DEPTH: cfg.min_depth <= cfg_data[drb_pkg::DEPTH_W-1:0];
        drb_pkg::REG_MAX_DEPTH: cfg.max_depth <= cfg_data[drb_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // front stalls only on a full queue
  drb_front #(
    .COLUMN_LIMIT (COLUMN_LIMIT),
    .ROW_LIMIT    (ROW_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .cfg       (cfg),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  drb_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (full),
    .empty     (empty)
  );

  // back stalls only on a point word that waits at the output
  drb_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_data (pop_data),
    .pop      (pop),
    .point    (point)
  );

endmodule

`default_nettype wire

// ===== hdl/drb_checker.sv =====
// port-level checks of the depth ray back-projection block, bound to its top level
// depends on drb_pkg and depth_ray_backprojection
`timescale 1ns / 1ps
`default_nettype none

module drb_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [drb_pkg::POINT_XY_W-1:0] point_x,
  input logic signed [drb_pkg::POINT_XY_W-1:0] point_y,
  input logic [drb_pkg::DEPTH_W-1:0]          point_z
);

  localparam logic [drb_pkg::POINT_XY_W-1:0] MOST_NEG = {1'b1, {drb_pkg::DEPTH_W{1'b0}}};

  // no point word survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("point word valid right after reset");

  // a waiting point word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
                                && $stable(point_z))
    else $error("stalled point word changed");

  // magnitudes never exceed the ray length, so the most negative code is unused
  a_sign_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (point_x != MOST_NEG) && (point_y != MOST_NEG))
    else $error("point coordinate out of range");

  // the queue fills only while the output side is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stalled without output stall");

endmodule

bind depth_ray_backprojection drb_checker u_drb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pixel.ready),
  .out_valid (point.valid),
  .out_ready (point.ready),
  .point_x   (point.point_x),
  .point_y   (point.point_y),
  .point_z   (point.point_z)
);

`default_nettype wire

// ===== test/drb_testbench.sv =====
// self-checking testbench of the depth ray back-projection block
// depends on drb_pkg, drb_channels and depth_ray_backprojection
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import drb_pkg::*;

  // one expected point word
  typedef struct {
    logic signed [POINT_XY_W-1:0] x;
    logic signed [POINT_XY_W-1:0] y;
    logic [DEPTH_W-1:0]           z;
    logic [COLOR_W-1:0]           r, g, b;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  drb_pixel_if pixel ();
  drb_point_if point ();

  depth_ray_backprojection i_dut (
    .clk(clk), .rst(rst), .pixel(pixel), .point(point),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // local copy of the camera registers
  logic signed [FOCAL_W-1:0] cam_fx;
  logic signed [FOCAL_W-1:0] cam_fy;
  logic [CENTER_W-1:0] cam_cx, cam_cy;
  logic [DEPTH_W-1:0]  cam_dmin, cam_dmax;

  point_t expected_points[$];
  int errors = 0;
  int points_seen = 0;
  int pixels_sent = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 1'b0;
  int hold_cycles = 0;

  localparam longint CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 120;
  // index with no register behind it
  localparam logic [CFG_INDEX_W-1:0] UNUSED_INDEX = 3'd7;

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at %0t", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint unsigned mag_of(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv >>= 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // rounded d*m/r, ties away from zero
  function automatic longint unsigned scaled(longint unsigned d, longint unsigned m,
                                             longint unsigned r);
    longint unsigned q;
    q = (d * m + (r >> 1)) / r;
    return q > 64'hFFFFF ? 64'hFFFFF : q;
  endfunction

  // back-projects one pixel; returns 0 when the pixel is dropped
  function automatic bit project_pixel(input logic [COL_W-1:0] u, input logic [ROW_W-1:0] v,
                                       input logic [DEPTH_W-1:0] d, input logic cp,
                                       input color_t c, output point_t p);
    longint a, b, fx, fy;
    longint unsigned ma, mb, mc, top, root;
    int k;
    fx = cam_fx;
    fy = cam_fy;
    if (d <= cam_dmin || d >= cam_dmax) return 1'b0;
    if (fx == 0 || fy == 0) return 1'b0;
    if (u >= COLUMN_LIMIT_DEFAULT || v >= ROW_LIMIT_DEFAULT) return 1'b0;
    a = longint'(u) * 256 - longint'(cam_cx);
    b = longint'(v) * 256 - longint'(cam_cy);
    ma = mag_of(a * fy);
    mb = mag_of(b * fx);
    mc = mag_of(fx * fy);
    top = ma;
    if (mb > top) top = mb;
    if (mc > top) top = mc;
    k = 0;
    while ((top >> k) >= (64'd1 << 31)) k++;
    ma >>= k;
    mb >>= k;
    mc >>= k;
    root = int_sqrt(ma * ma + mb * mb + mc * mc);
    if (root == 0) return 1'b0;
    ma = scaled(d, ma, root);
    mb = scaled(d, mb, root);
    mc = scaled(d, mc, root);
    p.x = ((a < 0) != (fx < 0)) ? -ma[POINT_XY_W-1:0] : ma[POINT_XY_W-1:0];
    p.y = ((b < 0) != (fy < 0)) ? -mb[POINT_XY_W-1:0] : mb[POINT_XY_W-1:0];
    p.z = mc[DEPTH_W-1:0];
    p.r = cp ? c.red : WHITE;
    p.g = cp ? c.green : WHITE;
    p.b = cp ? c.blue : WHITE;
    return 1'b1;
  endfunction

  // receiver: ready toggles at the falling edge, long hold-off on request
  initial begin
    point.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off && hold_cycles > 0) begin
        point.ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
        if (hold_cycles == 0) hold_off = 1'b0;
      end else begin
        point.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // checker: compares each accepted point word with the oldest expectation
  always @(posedge clk) begin
    point_t e;
    if (!rst && point.valid && point.ready) begin
      points_seen++;
      if (expected_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected point x=%0d y=%0d z=%0d", $time,
                 point.point_x, point.point_y, point.point_z);
      end else begin
        e = expected_points.pop_front();
        if (point.point_x !== e.x || point.point_y !== e.y || point.point_z !== e.z ||
            point.out_red !== e.r || point.out_green !== e.g || point.out_blue !== e.b) begin
          errors++;
          $display("%0t: mismatch expected x=%0d y=%0d z=%0d rgb=%0d,%0d,%0d", $time,
                   e.x, e.y, e.z, e.r, e.g, e.b);
          $display("%0t:            actual x=%0d y=%0d z=%0d rgb=%0d,%0d,%0d", $time,
                   point.point_x, point.point_y, point.point_z,
                   point.out_red, point.out_green, point.out_blue);
        end
      end
    end
  end

  // writes one camera register and mirrors it locally
  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_FOCAL_X:   cam_fx = val;
      REG_FOCAL_Y:   cam_fy = val;
      REG_CENTER_X:  cam_cx = val[CENTER_W-1:0];
      REG_CENTER_Y:  cam_cy = val[CENTER_W-1:0];
      REG_MIN_DEPTH: cam_dmin = val[DEPTH_W-1:0];
      REG_MAX_DEPTH: cam_dmax = val[DEPTH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // sends one pixel word, waits for acceptance, records the expected point;
  // valid stays high on return so that words can follow back to back
  task automatic send_pixel(input logic [COL_W-1:0] u, input logic [ROW_W-1:0] v,
                            input logic [DEPTH_W-1:0] d, input logic cp, input color_t c);
    point_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      pixel.valid <= 1'b0;
      @(negedge clk);
    end
    pixel.valid <= 1'b1;
    pixel.pixel_col <= u;
    pixel.pixel_row <= v;
    pixel.ray_depth <= d;
    pixel.color_present <= cp;
    pixel.in_red <= c.red;
    pixel.in_green <= c.green;
    pixel.in_blue <= c.blue;
    do @(posedge clk); while (!pixel.ready);
    if (project_pixel(u, v, d, cp, c, p)) expected_points = {expected_points, p};
    pixels_sent++;
    @(negedge clk);
  endtask

  // stops offering, waits until every expected point has come, lets the pipeline empty
  task automatic drain();
    pixel.valid <= 1'b0;
    while (expected_points.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic color_t any_color();
    return color_t'(24'($urandom));
  endfunction

  // depth strictly inside the current range, or any depth when the range is empty
  function automatic logic [DEPTH_W-1:0] good_depth();
    if (cam_dmax <= cam_dmin + 1) return DEPTH_W'($urandom);
    return DEPTH_W'($urandom_range(cam_dmax - 1, cam_dmin + 1));
  endfunction

  task automatic test_directed();
    color_t c;
    c = '{8'h00, 8'hFF, 8'hA5};
    // depth bounds and neighbours
    send_pixel(12'd320, 12'd240, cam_dmin, 1'b1, c);
    send_pixel(12'd320, 12'd240, cam_dmin + 20'd1, 1'b1, c);
    send_pixel(12'd320, 12'd240, cam_dmax, 1'b0, c);
    send_pixel(12'd320, 12'd240, cam_dmax - 20'd1, 1'b0, c);
    send_pixel(12'd0, 12'd0, 20'd0, 1'b1, c);
    send_pixel(12'd0, 12'd0, 20'hFFFFF, 1'b1, c);
    // image corners and field extremes
    send_pixel(12'd0, 12'd0, 20'd65536, 1'b1, '{8'hFF, 8'h00, 8'h5A});
    send_pixel(12'hFFF, 12'd0, 20'd65536, 1'b0, c);
    send_pixel(12'd0, 12'hFFF, 20'd65536, 1'b1, '{8'h00, 8'h00, 8'h00});
    send_pixel(12'hFFF, 12'hFFF, 20'd655359, 1'b1, '{8'hFF, 8'hFF, 8'hFF});
    send_pixel(12'd319, 12'd239, 20'd131072, 1'b1, c);
    drain();
    // zero focal length drops everything
    write_reg(REG_FOCAL_X, '0);
    send_pixel(12'd10, 12'd20, 20'd70000, 1'b1, c);
    drain();
    write_reg(REG_FOCAL_X, 21'd123187);
    write_reg(REG_FOCAL_Y, '0);
    send_pixel(12'd10, 12'd20, 20'd70000, 1'b1, c);
    drain();
    write_reg(REG_FOCAL_Y, -21'sd122880);
    // unknown register index must be ignored
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= UNUSED_INDEX;
    cfg_data <= '0;
    @(negedge clk);
    cfg_we <= 1'b0;
    send_pixel(12'd100, 12'd100, 20'd80000, 1'b0, c);
    drain();
  endtask

  // random pixels: mostly inside the range, some dropped
  task automatic test_random(input int n);
    logic [DEPTH_W-1:0] d;
    for (int i = 0; i < n; i++) begin
      d = ($urandom_range(9) < 8) ? good_depth()
        : logic'($urandom) ? cam_dmin : DEPTH_W'($urandom);
      send_pixel(COL_W'($urandom), ROW_W'($urandom), d, 1'($urandom), any_color());
    end
  endtask

  // sweeps camera settings, extremes among them
  task automatic test_settings();
    logic [CFG_DATA_W-1:0] fx_set[4] = '{21'h0FFFFF, 21'h100000, 21'd256, -21'sd256};
    logic [CFG_DATA_W-1:0] fy_set[4] = '{21'h100000, 21'h0FFFFF, -21'sd1, 21'd1};
    for (int s = 0; s < 4; s++) begin
      write_reg(REG_FOCAL_X, fx_set[s]);
      write_reg(REG_FOCAL_Y, fy_set[s]);
      write_reg(REG_CENTER_X, s[0] ? 21'h0FFFFF : 21'd0);
      write_reg(REG_CENTER_Y, s[1] ? 21'h0FFFFF : CFG_DATA_W'($urandom_range(1048575)));
      write_reg(REG_MIN_DEPTH, s == 3 ? 21'd0 : CFG_DATA_W'($urandom_range(1000)));
      write_reg(REG_MAX_DEPTH,
                s == 0 ? 21'h0FFFFF : CFG_DATA_W'($urandom_range(1048575, 300000)));
      test_random(40);
      drain();
    end
    // min above max drops every pixel
    write_reg(REG_MIN_DEPTH, 21'h0FFFFF);
    write_reg(REG_MAX_DEPTH, 21'd0);
    test_random(10);
    drain();
    write_reg(REG_FOCAL_X, CFG_DATA_W'($urandom_range(200000, 50000)));
    write_reg(REG_FOCAL_Y, CFG_DATA_W'(-$urandom_range(200000, 50000)));
    write_reg(REG_CENTER_X, 21'd81792);
    write_reg(REG_CENTER_Y, 21'd61312);
    write_reg(REG_MIN_DEPTH, 21'd655);
    write_reg(REG_MAX_DEPTH, 21'd655360);
  endtask

  // receiver holds off while pixels keep coming, so the input stalls
  task automatic test_backpressure();
    hold_cycles = 300;
    hold_off = 1'b1;
    test_random(120);
    drain();
  endtask

  initial begin
    pixel.valid = 1'b0;
    pixel.pixel_col = '0;
    pixel.pixel_row = '0;
    pixel.ray_depth = '0;
    pixel.color_present = 1'b0;
    pixel.in_red = '0;
    pixel.in_green = '0;
    pixel.in_blue = '0;
    cam_fx = FOCAL_X_RESET;
    cam_fy = FOCAL_Y_RESET;
    cam_cx = CENTER_X_RESET;
    cam_cy = CENTER_Y_RESET;
    cam_dmin = MIN_DEPTH_RESET;
    cam_dmax = MAX_DEPTH_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender idles a quarter of the time, receiver most of it
    send_idle_pct = 25;
    recv_idle_pct = 60;
    test_directed();
    test_random(150);
    drain();
    test_settings();
    // roles swapped
    send_idle_pct = 60;
    recv_idle_pct = 25;
    test_random(150);
    drain();
    // full rate both ways
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(150);
    drain();

    $display("sent %0d pixel words, checked %0d point words over %0d cycles",
             pixels_sent, points_seen, cycles);
    $display("covered depth bounds, zero focal lengths, register extremes and stalls");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

`default_nettype wire
